FILE: hw/rtl/joystick_polar_deadzone_top_defines.svh
// assertion macros used by the top-level rtl file
`ifndef JOYSTICK_POLAR_DEADZONE_TOP_DEFINES_SVH
`define JOYSTICK_POLAR_DEADZONE_TOP_DEFINES_SVH

// plain property on clk_i, off during reset
`define JPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// overlapping implication on clk_i, off during reset
`define JPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/jpd_pkg.sv
package jpd_pkg;

  localparam int unsigned SampleBits  = 10;
  localparam int unsigned CordicSteps = 16;

  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CenterW = 10;
  localparam int unsigned OffsetW = 8;
  localparam int unsigned ScaleW  = 16;
  localparam int unsigned DzW     = 11;
  localparam int unsigned GainW   = 16;

  localparam logic [CenterW-1:0] CenterMainReset = 10'd512;
  localparam logic [CenterW-1:0] CenterAuxReset  = 10'd325;
  localparam logic [OffsetW-1:0] AuxOffsetReset  = 8'd15;
  localparam logic [ScaleW-1:0]  AuxScaleReset   = 16'd25811;
  localparam logic [DzW-1:0]     DeadzoneReset   = 11'd50;
  localparam logic [GainW-1:0]   BendGainReset   = 16'd4096;

  // datapath widths
  localparam int unsigned DiffW     = 14;
  localparam int unsigned AuxProdW  = DiffW + ScaleW + 1;
  localparam int unsigned FracShift = 14;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned SqW       = 32;
  localparam int unsigned DzSqW     = 2 * DzW;
  localparam int unsigned CordFrac  = 16;
  localparam int unsigned CordW     = 34;
  localparam int unsigned ZW        = 32;
  localparam int unsigned AngRawW   = 16;
  localparam int unsigned AngW      = 15;
  localparam int unsigned KinvW     = 30;
  localparam int unsigned ProdW     = CordW - 1 + KinvW;
  localparam int unsigned MagShift  = 42;
  localparam int unsigned MagFullW  = ProdW - MagShift;
  localparam int unsigned MagW      = 16;
  localparam int unsigned BendW     = 16;
  localparam int unsigned BendShift = 10;
  localparam int unsigned BendProdW = MagFullW + GainW;
  localparam int unsigned BendShW   = BendProdW - BendShift;

  localparam int AngFull  = 23040;
  localparam int ZHalfInt = (AngFull / 2) * (1 << CordFrac);
  localparam int ZRound   = 1 << (CordFrac - 1);
  localparam int BendOne  = 32768;
  localparam int MagMax   = 65535;

  localparam logic signed [ZW-1:0] ZHalf = ZW'(ZHalfInt);
  localparam logic [KinvW-1:0]     Kinv  = KinvW'(652032874);
  localparam logic [DzSqW-1:0]     DzSqReset = DzSqW'(DeadzoneReset * DeadzoneReset);

  typedef enum logic [CfgIdxW-1:0] {
    CfgCenterMain = 3'd0,
    CfgCenterAux  = 3'd1,
    CfgAuxOffset  = 3'd2,
    CfgAuxScale   = 3'd3,
    CfgDeadzone   = 3'd4,
    CfgBendGain   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [SampleBits-1:0] main_x;
    logic [SampleBits-1:0] main_y;
    logic [SampleBits-1:0] aux_x;
    logic [SampleBits-1:0] aux_y;
  } jpd_in_t;

  typedef struct packed {
    logic [AngW-1:0]  angle;
    logic [BendW-1:0] bend;
    logic [MagW-1:0]  magnitude;
  } jpd_out_t;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [ZW-1:0]    z;
    logic                    zero;
  } jpd_cord_t;

  // arctangent of 2^-idx, 1/64 degree scaled by 2^16
  function automatic logic signed [ZW-1:0] atan_z(input int unsigned idx);
    logic signed [ZW-1:0] r;
    case (idx)
      0:       r = ZW'(188743680);
      1:       r = ZW'(111421900);
      2:       r = ZW'(58872272);
      3:       r = ZW'(29884485);
      4:       r = ZW'(15000234);
      5:       r = ZW'(7507429);
      6:       r = ZW'(3754631);
      7:       r = ZW'(1877430);
      8:       r = ZW'(938729);
      9:       r = ZW'(469366);
      10:      r = ZW'(234683);
      11:      r = ZW'(117342);
      12:      r = ZW'(58671);
      13:      r = ZW'(29335);
      14:      r = ZW'(14668);
      15:      r = ZW'(7334);
      16:      r = ZW'(3667);
      17:      r = ZW'(1833);
      18:      r = ZW'(917);
      19:      r = ZW'(458);
      20:      r = ZW'(229);
      21:      r = ZW'(115);
      22:      r = ZW'(57);
      23:      r = ZW'(29);
      default: r = '0;
    endcase
    return r;
  endfunction

  // one vectoring step, shifts floor
  function automatic jpd_cord_t cordic_iter(input jpd_cord_t c, input int unsigned k);
    jpd_cord_t r;
    logic signed [CordW-1:0] xs;
    logic signed [CordW-1:0] ys;
    r  = c;
    xs = c.x >>> k;
    ys = c.y >>> k;
    if (!c.y[CordW-1]) begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.z = c.z + atan_z(k);
    end else begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.z = c.z - atan_z(k);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/jpd_cordic.sv
module jpd_cordic import jpd_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CordicSteps
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      in_valid_i,
  input  jpd_cord_t in_i,
  output logic      out_valid_o,
  output jpd_cord_t out_o
);

  jpd_cord_t                stage_q [CORDIC_STEPS];
  jpd_cord_t                nxt     [CORDIC_STEPS];
  logic [CORDIC_STEPS-1:0]  valid_q;

  // one iteration per register stage
  always_comb begin
    nxt[0] = cordic_iter(in_i, 0);
    for (int unsigned k = 1; k < CORDIC_STEPS; k++) begin
      nxt[k] = cordic_iter(stage_q[k-1], k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[CORDIC_STEPS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int unsigned k = 0; k < CORDIC_STEPS; k++) begin
        stage_q[k] <= nxt[k];
      end
    end
  end

  assign out_valid_o = valid_q[CORDIC_STEPS-1];
  assign out_o       = stage_q[CORDIC_STEPS-1];

endmodule

FILE: hw/rtl/joystick_polar_deadzone_top.sv
// Joystick to polar converter. Each item holds a main and an auxiliary sample pair; the
// main pair is centered, the auxiliary pair is centered, offset and scaled, and the two are
// summed into X and Y. Items whose vector lies inside the deadzone give no result; all
// others give angle (1/64 degree, 0 up to 360), magnitude (Q12.4, saturating) and bend
// (Q1.15, saturating at 1.0). One item is taken every cycle while in_stall_o is low. An
// item passes through CORDIC_STEPS + 9 register stages: five input stages, the unrolled
// CORDIC with one iteration per stage, three output stages and the output register. The
// first stage loads on the accepting edge. An output register with a one-entry skid stage
// lets the input side keep going after the output stalls, until the skid stage fills.
// Configuration registers are written through a plain write port.

`include "joystick_polar_deadzone_top_defines.svh"

module joystick_polar_deadzone_top import jpd_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CordicSteps
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  jpd_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output jpd_out_t           out_data_o
);

  // configuration
  logic [CenterW-1:0] center_main_q;
  logic [CenterW-1:0] center_aux_q;
  logic [OffsetW-1:0] aux_offset_q;
  logic [ScaleW-1:0]  aux_scale_q;
  logic [DzW-1:0]     deadzone_q;
  logic [GainW-1:0]   bend_gain_q;
  logic [DzSqW-1:0]   dz_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_main_q <= CenterMainReset;
      center_aux_q  <= CenterAuxReset;
      aux_offset_q  <= AuxOffsetReset;
      aux_scale_q   <= AuxScaleReset;
      deadzone_q    <= DeadzoneReset;
      bend_gain_q   <= BendGainReset;
      dz_sq_q       <= DzSqReset;
    end else begin
      dz_sq_q <= DzSqW'(deadzone_q * deadzone_q);
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CfgCenterMain: center_main_q <= cfg_data_i[CenterW-1:0];
          CfgCenterAux:  center_aux_q  <= cfg_data_i[CenterW-1:0];
          CfgAuxOffset:  aux_offset_q  <= cfg_data_i[OffsetW-1:0];
          CfgAuxScale:   aux_scale_q   <= cfg_data_i[ScaleW-1:0];
          CfgDeadzone:   deadzone_q    <= cfg_data_i[DzW-1:0];
          CfgBendGain:   bend_gain_q   <= cfg_data_i[GainW-1:0];
          default: ;
        endcase
      end
    end
  end

  // flow control
  logic pipe_en;
  logic skid_valid_q;
  logic out_valid_q;

  assign pipe_en    = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // stage 1: centering
  logic                    s1_valid_q;
  logic signed [DiffW-1:0] mx_d, my_d, dx_d, dy_d;
  logic signed [DiffW-1:0] mx_q, my_q, dx_q, dy_q;
  logic [DiffW-1:0]        main_c, aux_c;

  assign main_c = {{(DiffW-CenterW){1'b0}}, center_main_q};
  assign aux_c  = {{(DiffW-CenterW){1'b0}}, center_aux_q}
                + {{(DiffW-OffsetW){1'b0}}, aux_offset_q};
  assign mx_d = $signed({{(DiffW-SampleBits){1'b0}}, in_data_i.main_x} - main_c);
  assign my_d = $signed({{(DiffW-SampleBits){1'b0}}, in_data_i.main_y} - main_c);
  assign dx_d = $signed({{(DiffW-SampleBits){1'b0}}, in_data_i.aux_x} - aux_c);
  assign dy_d = $signed({{(DiffW-SampleBits){1'b0}}, in_data_i.aux_y} - aux_c);

  // stage 2: auxiliary scaling
  logic                       s2_valid_q;
  logic signed [DiffW-1:0]    s2_mx_q, s2_my_q;
  logic signed [AuxProdW-1:0] pax_d, pay_d, pax_q, pay_q;

  assign pax_d = dx_q * $signed({1'b0, aux_scale_q});
  assign pay_d = dy_q * $signed({1'b0, aux_scale_q});

  // stage 3: sum
  logic                       s3_valid_q;
  logic signed [AuxProdW-1:0] shx, shy;
  logic signed [CoordW-1:0]   cx_d, cy_d, cx_q, cy_q;

  assign shx  = pax_q >>> FracShift;
  assign shy  = pay_q >>> FracShift;
  assign cx_d = CoordW'(s2_mx_q) + $signed(shx[CoordW-1:0]);
  assign cy_d = CoordW'(s2_my_q) + $signed(shy[CoordW-1:0]);

  // stage 4: squares
  logic                     s4_valid_q;
  logic signed [CoordW-1:0] s4_x_q, s4_y_q;
  logic signed [SqW-1:0]    xx_d, yy_d;
  logic [SqW-1:0]           xx_q, yy_q;
  logic [SqW-1:0]           sq_sum;

  assign xx_d   = cx_q * cx_q;
  assign yy_d   = cy_q * cy_q;
  assign sq_sum = xx_q + yy_q;

  // stage 5: deadzone and cordic start
  logic                    keep;
  logic                    s4_neg;
  logic signed [CordW-1:0] x0, y0;
  jpd_cord_t               cord_d, cord_q;
  logic                    cord_valid_q;

  assign keep   = sq_sum >= {{(SqW-DzSqW){1'b0}}, dz_sq_q};
  assign s4_neg = s4_x_q[CoordW-1];
  assign x0     = CordW'(s4_x_q) <<< CordFrac;
  assign y0     = CordW'(s4_y_q) <<< CordFrac;

  always_comb begin
    cord_d.x    = s4_neg ? -x0 : x0;
    cord_d.y    = s4_neg ? -y0 : y0;
    cord_d.z    = s4_neg ? ZHalf : '0;
    cord_d.zero = (s4_x_q == '0) && (s4_y_q == '0);
  end

  logic      cord_out_valid;
  jpd_cord_t cord_out;

  jpd_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .in_valid_i (cord_valid_q),
    .in_i       (cord_q),
    .out_valid_o(cord_out_valid),
    .out_o      (cord_out)
  );

  // stage 6: angle rounding and wrap
  logic                      s6_valid_q;
  logic signed [ZW-1:0]      zr;
  logic signed [ZW-1:0]      zr_sh;
  logic signed [AngRawW-1:0] ang_r;
  logic signed [AngRawW:0]   ang_w;
  logic [AngW-1:0]           ang_d, s6_ang_q;
  logic [CordW-2:0]          xc_d, xc_q;

  assign zr    = cord_out.z + ZW'(ZRound);
  assign zr_sh = zr >>> CordFrac;
  assign ang_r = $signed(zr_sh[AngRawW-1:0]);

  always_comb begin
    if (ang_r < 0) begin
      ang_w = (AngRawW+1)'(ang_r + AngFull);
    end else if (ang_r >= AngFull) begin
      ang_w = (AngRawW+1)'(ang_r - AngFull);
    end else begin
      ang_w = (AngRawW+1)'(ang_r);
    end
    ang_d = cord_out.zero ? '0 : ang_w[AngW-1:0];
    xc_d  = cord_out.x[CordW-1] ? '0 : cord_out.x[CordW-2:0];
  end

  // stage 7: gain correction
  logic             s7_valid_q;
  logic [AngW-1:0]  s7_ang_q;
  logic [ProdW-1:0] kprod_q;

  // stage 8: bend product
  logic                 s8_valid_q;
  logic [AngW-1:0]      s8_ang_q;
  logic [MagFullW-1:0]  mag_full;
  logic [MagFullW-1:0]  mag_q;
  logic [BendProdW-1:0] bend_prod_q;

  assign mag_full = kprod_q[ProdW-1:MagShift];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      s3_valid_q   <= 1'b0;
      s4_valid_q   <= 1'b0;
      cord_valid_q <= 1'b0;
      s6_valid_q   <= 1'b0;
      s7_valid_q   <= 1'b0;
      s8_valid_q   <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_q   <= in_valid_i;
      s2_valid_q   <= s1_valid_q;
      s3_valid_q   <= s2_valid_q;
      s4_valid_q   <= s3_valid_q;
      cord_valid_q <= s4_valid_q && keep;
      s6_valid_q   <= cord_out_valid;
      s7_valid_q   <= s6_valid_q;
      s8_valid_q   <= s7_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      mx_q        <= mx_d;
      my_q        <= my_d;
      dx_q        <= dx_d;
      dy_q        <= dy_d;
      s2_mx_q     <= mx_q;
      s2_my_q     <= my_q;
      pax_q       <= pax_d;
      pay_q       <= pay_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      s4_x_q      <= cx_q;
      s4_y_q      <= cy_q;
      xx_q        <= $unsigned(xx_d);
      yy_q        <= $unsigned(yy_d);
      cord_q      <= cord_d;
      s6_ang_q    <= ang_d;
      xc_q        <= xc_d;
      s7_ang_q    <= s6_ang_q;
      kprod_q     <= xc_q * Kinv;
      s8_ang_q    <= s7_ang_q;
      mag_q       <= mag_full;
      bend_prod_q <= mag_full * bend_gain_q;
    end
  end

  // output saturation
  logic [BendShW-1:0] bend_sh;
  jpd_out_t           pipe_out;

  assign bend_sh = bend_prod_q[BendProdW-1:BendShift];

  always_comb begin
    pipe_out.angle     = s8_ang_q;
    pipe_out.bend      = (bend_sh > BendShW'(BendOne)) ? BendW'(BendOne)
                                                       : bend_sh[BendW-1:0];
    pipe_out.magnitude = (mag_q > MagFullW'(MagMax)) ? MagW'(MagMax) : mag_q[MagW-1:0];
  end

  // output register and skid stage
  jpd_out_t out_q, skid_q;
  logic     out_free;
  logic     pipe_leave;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign pipe_leave = s8_valid_q && pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || pipe_leave;
      skid_valid_q <= 1'b0;
    end else if (pipe_leave) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : pipe_out;
    end else if (pipe_leave) begin
      skid_q <= pipe_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `JPD_ASSERT(a_skid_needs_out, skid_valid_q |-> out_valid_q, "skid full with empty output")
  `JPD_ASSERT_IMP(a_skid_fill, $rose(skid_valid_q), $past(out_valid_q && out_stall_i),
    "skid filled without output stall")
  `JPD_ASSERT(a_hold_tail, !pipe_en |=> $stable(s8_valid_q), "pipeline moved while held")
  `JPD_ASSERT(a_deadzone_drop, (pipe_en && s4_valid_q && !keep) |=> !cord_valid_q,
    "item inside deadzone not dropped")
  `JPD_ASSERT_IMP(a_angle_range, out_valid_q, out_q.angle < AngW'(AngFull),
    "angle out of range")

endmodule
